[hdl/nmh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmh_pkg
// Shared constants of the height-to-normal-map block.
// ----------------------------------------------------------------------------
package nmh_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 256;
   localparam int DEFAULT_MAX_HEIGHT = 256;

   // configuration register indexes
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_STRENGTH     = 2'd2;

   localparam logic [8:0]  RESET_IMAGE_WIDTH  = 9'd256;
   localparam logic [8:0]  RESET_IMAGE_HEIGHT = 9'd256;
   localparam logic [15:0] RESET_STRENGTH     = 16'd256;

   // item operation codes
   localparam logic OP_STORE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // z component scale: 9 * 255 in the Q8.8 domain of strength
   localparam int VZ_SCALE = 2295;

   localparam int HEIGHT_W = 10;
   localparam int VZ_W     = 28;
   localparam int SQ_W     = 56;
   localparam int ROOT_W   = 28;
   localparam int NUM_W    = 38;

endpackage

[hdl/normal_map_from_height.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normal_map_from_height
// Height image to RGB normal map by central differences with wrap-around.
// ----------------------------------------------------------------------------
// A store item (operation 0) writes R+G+B of one pixel into the height memory
// and busy stays low. A query item (operation 1) reads the four neighbours
// one after another through the single memory port, squares the vector
// components on one shared multiplier, sums them, takes an integer square
// root one result bit a cycle, prepares the numerators and runs three 8-step
// restoring dividers side by side: busy is high throughout, and the result
// strobe rsp_valid is high in the cycle after the last busy cycle. A flat pixel
// with zero strength answers from the sum step with 128 in all three components.
// Items outside the image are dropped without a result. Results are shown for
// exactly one cycle and must be taken then; start may be raised again in that
// same cycle.
// ----------------------------------------------------------------------------
module normal_map_from_height
   import nmh_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [7:0]  req_column,
   input  logic [7:0]  req_row,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   output logic [7:0]  rsp_normal_x,
   output logic [7:0]  rsp_normal_y,
   output logic [7:0]  rsp_normal_z,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_MUL, ST_SUM, ST_SQRT, ST_PREP, ST_DIV
   } state_type;

   // configuration
   logic [8:0]  width_reg_ff, height_reg_ff;
   logic [15:0] strength_ff;
   logic        csr_we;

   assign pready = 1'b1;
   assign csr_we = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= RESET_IMAGE_WIDTH;
         height_reg_ff <= RESET_IMAGE_HEIGHT;
         strength_ff   <= RESET_STRENGTH;
      end else if (csr_we) begin
         unique case (paddr[3:2])
            REG_IMAGE_WIDTH:  width_reg_ff  <= pwdata[8:0];
            REG_IMAGE_HEIGHT: height_reg_ff <= pwdata[8:0];
            REG_STRENGTH:     strength_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_IMAGE_WIDTH:  prdata = {23'd0, width_reg_ff};
         REG_IMAGE_HEIGHT: prdata = {23'd0, height_reg_ff};
         REG_STRENGTH:     prdata = {16'd0, strength_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // effective image size
   logic [8:0] img_w, img_h;
   always_comb begin
      if (width_reg_ff == 9'd0)                img_w = 9'd1;
      else if (32'(width_reg_ff) > MAX_WIDTH)  img_w = 9'(MAX_WIDTH);
      else                                     img_w = width_reg_ff;
      if (height_reg_ff == 9'd0)               img_h = 9'd1;
      else if (32'(height_reg_ff) > MAX_HEIGHT) img_h = 9'(MAX_HEIGHT);
      else                                     img_h = height_reg_ff;
   end

   // accept and neighbour coordinates
   state_type state_ff;
   logic      accept, in_range, mem_we;
   logic [7:0] xl, xr, yu, yd;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start & ~busy;
   assign in_range = ({1'b0, req_column} < img_w) && ({1'b0, req_row} < img_h);
   assign mem_we   = accept & in_range & (req_operation == OP_STORE);

   always_comb begin
      xl = (req_column == 8'd0) ? 8'(img_w - 9'd1) : req_column - 8'd1;
      xr = ({1'b0, req_column} + 9'd1 >= img_w) ? 8'd0 : req_column + 8'd1;
      yu = (req_row == 8'd0) ? 8'(img_h - 9'd1) : req_row - 8'd1;
      yd = ({1'b0, req_row} + 9'd1 >= img_h) ? 8'd0 : req_row + 8'd1;
   end

   function automatic logic [ADDR_W-1:0] pix_addr(input logic [7:0] x, input logic [7:0] y);
      pix_addr = ADDR_W'(32'(y) * MAX_WIDTH + 32'(x));
   endfunction

   // height memory
   logic [HEIGHT_W-1:0] height_mem [DEPTH];
   logic [HEIGHT_W-1:0] rdata_ff;
   logic [ADDR_W-1:0]   mem_addr;
   logic [HEIGHT_W-1:0] wdata;
   logic [ADDR_W-1:0]   nb_addr_ff [4];
   logic [4:0]          cnt_ff;

   assign wdata = 10'(req_red) + 10'(req_green) + 10'(req_blue);

   always_comb begin
      if (state_ff == ST_READ) mem_addr = nb_addr_ff[cnt_ff[1:0]];
      else                     mem_addr = pix_addr(req_column, req_row);
   end

   always_ff @(posedge clock) begin
      if (mem_we) height_mem[mem_addr] <= wdata;
      rdata_ff <= height_mem[mem_addr];
   end

   // datapath
   logic [HEIGHT_W-1:0] h_ff [4];
   logic [VZ_W-1:0]     vz_ff;
   logic [SQ_W-1:0]     sq_ff [3];
   logic [SQ_W-1:0]     q_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [31:0]         srem_ff;
   logic [NUM_W-1:0]    rem_ff [3];
   logic [7:0]          quo_ff [3];
   logic signed [10:0]  dsx, dsy;
   logic [VZ_W-1:0]     mul_a;
   logic [SQ_W-1:0]     sq_sum;
   logic [31:0]         srem_sh, strial;
   logic signed [39:0]  num [3];
   logic [NUM_W-1:0]    dsor;

   assign dsx = $signed({1'b0, h_ff[0]}) - $signed({1'b0, h_ff[1]});
   assign dsy = $signed({1'b0, h_ff[2]}) - $signed({1'b0, h_ff[3]});

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    mul_a = VZ_W'(dsx[10] ? -dsx : dsx);
         2'd1:    mul_a = VZ_W'(dsy[10] ? -dsy : dsy);
         default: mul_a = vz_ff;
      endcase
   end

   assign sq_sum  = (sq_ff[0] << 16) + (sq_ff[1] << 16) + sq_ff[2];
   assign srem_sh = {srem_ff[29:0], q_ff[SQ_W-1 -: 2]};
   assign strial  = {2'b00, root_ff, 2'b01};

   // vx = -256*dsx, so 255*vx = -65280*dsx
   assign num[0] = $signed({4'd0, root_ff, 8'd0}) - 40'sd65280 * 40'(dsx);
   assign num[1] = $signed({4'd0, root_ff, 8'd0}) - 40'sd65280 * 40'(dsy);
   assign num[2] = $signed({4'd0, root_ff, 8'd0}) + 40'sd255 * $signed({12'd0, vz_ff});
   assign dsor   = NUM_W'({root_ff, 1'b0}) << cnt_ff[2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= 5'd0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == ST_SUM && sq_sum == '0)
                      || (state_ff == ST_DIV && cnt_ff == 5'd0);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && in_range && req_operation == OP_QUERY) begin
                  nb_addr_ff[0] <= pix_addr(xr, req_row);
                  nb_addr_ff[1] <= pix_addr(xl, req_row);
                  nb_addr_ff[2] <= pix_addr(req_column, yd);
                  nb_addr_ff[3] <= pix_addr(req_column, yu);
                  vz_ff    <= VZ_W'(VZ_SCALE * 32'(strength_ff));
                  cnt_ff   <= 5'd0;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               if (cnt_ff != 5'd0) h_ff[2'(cnt_ff - 5'd1)] <= rdata_ff;
               if (cnt_ff == 5'd4) begin
                  cnt_ff   <= 5'd0;
                  state_ff <= ST_MUL;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            ST_MUL: begin
               sq_ff[2'(cnt_ff)] <= mul_a * mul_a;
               if (cnt_ff == 5'd2) state_ff <= ST_SUM;
               else                cnt_ff   <= cnt_ff + 5'd1;
            end
            ST_SUM: begin
               if (sq_sum == '0) begin
                  rsp_normal_x <= 8'd128;
                  rsp_normal_y <= 8'd128;
                  rsp_normal_z <= 8'd128;
                  state_ff     <= ST_IDLE;
               end else begin
                  q_ff     <= sq_sum;
                  root_ff  <= '0;
                  srem_ff  <= '0;
                  cnt_ff   <= 5'(ROOT_W - 1);
                  state_ff <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               // one root bit a cycle, two radicand bits shifted in
               q_ff <= q_ff << 2;
               if (srem_sh >= strial) begin
                  srem_ff <= srem_sh - strial;
                  root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
               end else begin
                  srem_ff <= srem_sh;
                  root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
               end
               if (cnt_ff == 5'd0) state_ff <= ST_PREP;
               else                cnt_ff   <= cnt_ff - 5'd1;
            end
            ST_PREP: begin
               for (int k = 0; k < 3; k++) begin
                  rem_ff[k] <= num[k][39] ? '0 : num[k][NUM_W-1:0];
                  quo_ff[k] <= 8'd0;
               end
               cnt_ff   <= 5'd7;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               for (int k = 0; k < 3; k++) begin
                  if (rem_ff[k] >= dsor) begin
                     rem_ff[k]             <= rem_ff[k] - dsor;
                     quo_ff[k][cnt_ff[2:0]] <= 1'b1;
                  end
               end
               if (cnt_ff == 5'd0) begin
                  rsp_normal_x <= (rem_ff[0] >= dsor) ? (quo_ff[0] | 8'd1) : quo_ff[0];
                  rsp_normal_y <= (rem_ff[1] >= dsor) ? (quo_ff[1] | 8'd1) : quo_ff[1];
                  rsp_normal_z <= (rem_ff[2] >= dsor) ? (quo_ff[2] | 8'd1) : quo_ff[2];
                  state_ff     <= ST_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - 5'd1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // assertions
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid))
      else $error("two results in consecutive cycles");

   a_z_half: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_z >= 8'd128)
      else $error("z component below 128");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == ST_IDLE)
      else $error("height write during a query");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) != ST_IDLE)
      else $error("result without a query in progress");

endmodule
